[rtl/core/unique_shell_quartet_generator_assert.svh]
// assertion macros for the checker of the quartet generator
`ifndef UNIQUE_SHELL_QUARTET_GENERATOR_ASSERT_SVH
`define UNIQUE_SHELL_QUARTET_GENERATOR_ASSERT_SVH

// same-cycle implication, quiet while reset is asserted
`define USQG_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("usqg: same-cycle check failed");

// next-cycle implication, quiet while reset is asserted
`define USQG_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("usqg: next-cycle check failed");

// next-cycle implication that also covers the reset cycles
`define USQG_ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("usqg: reset check failed");

`endif

[rtl/core/usqg_pkg.sv]
`timescale 1ns / 1ps

package usqg_pkg;

    // command codes of the input transaction
    localparam logic [1:0] CMD_LOAD    = 2'd0;
    localparam logic [1:0] CMD_START   = 2'd1;
    localparam logic [1:0] CMD_ADVANCE = 2'd2;

    // fixed field widths
    localparam int CMD_W   = 2;
    localparam int IDX_W   = 8;
    localparam int AMV_W   = 4;
    localparam int CNT_CFG = 9;
    localparam int SHELL_W = 8;

    // wide enough for the config register and for a shell count parameter up to 131071
    localparam int XW = 17;

    // flags that stage one carries with its quartet into table ordering
    typedef struct packed {
        logic finished;
        logic eog;
    } t_s1_flags;

endpackage

[rtl/core/unique_shell_quartet_generator.sv]
`timescale 1ns / 1ps

// Walks the symmetry-unique shell quartets i >= j >= k >= l of one basis set and
// gives one permutation per start or advance transaction, ordered by angular
// momentum. A new transaction is taken every cycle unless a stalled result holds
// the input off; stage one registers the counters and the angular momentum table
// reads, and stage two orders the quartet into the output register. Four table lookups a
// cycle come from two copies of the table, each with two read ports; a load
// writes both copies and gives no result. The table must be loaded before the
// shells it holds are enumerated. Load and unused commands are taken at the same
// rate and leave nothing on the output. The shell count register is written
// through its own channel, which is always ready.
module unique_shell_quartet_generator
    import usqg_pkg::*;
#(
    parameter int MAX_SHELLS = 256,
    parameter int AM_BITS    = 4
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // input transactions
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [CMD_W-1:0]   i_command,
    input  logic [IDX_W-1:0]   i_shell_index,
    input  logic [AMV_W-1:0]   i_am_value,
    // result transactions
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [SHELL_W-1:0] o_shell_p,
    output logic [SHELL_W-1:0] o_shell_q,
    output logic [SHELL_W-1:0] o_shell_r,
    output logic [SHELL_W-1:0] o_shell_s,
    output logic               o_end_of_group,
    output logic               o_finished,
    // configuration
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [CNT_CFG-1:0] i_cfg_data
);

    localparam int CW = $clog2(MAX_SHELLS + 1);
    localparam int AW = (MAX_SHELLS > 1) ? $clog2(MAX_SHELLS) : 1;
    localparam int SW = AM_BITS + 1;

    // group size from the four counters
    function automatic logic [1:0] grp_size_of(input logic [CW-1:0] i, input logic [CW-1:0] j,
                                               input logic [CW-1:0] k, input logic [CW-1:0] l);
        logic [1:0] gs;
        if ((i == j && i == k) || (j == k && j == l)) begin
            gs = 2'd1;
        end else if (i == k || j == l || j == k || i == j || k == l) begin
            gs = 2'd2;
        end else begin
            gs = 2'd3;
        end
        return gs;
    endfunction

    logic [CNT_CFG-1:0] r_shell_count;
    logic [CW-1:0]      r_cnt_i, r_cnt_j, r_cnt_k, r_cnt_l;
    logic [CW-1:0]      n_cnt_i, n_cnt_j, n_cnt_k, n_cnt_l;
    logic [1:0]         r_grp_pos, n_grp_pos;
    logic [1:0]         r_grp_size, n_grp_size;
    logic               r_done, n_done;
    logic               n_finished;

    logic               r_s1_valid;
    t_s1_flags          r_s1_flags;
    t_s1_flags          n_s1_flags;
    logic [CW-1:0]      r_s1_p, r_s1_q, r_s1_r, r_s1_s;
    logic [CW-1:0]      n_s1_q, n_s1_r, n_s1_s;

    logic               r_out_valid;
    logic [SHELL_W-1:0] r_out_p, r_out_q, r_out_r, r_out_s;
    logic [SHELL_W-1:0] n_out_p, n_out_q, n_out_r, n_out_s;
    logic               r_out_eog, r_out_finished;

    logic               w_s1_adv;
    logic               w_accept;
    logic               w_emit;
    logic               w_load;
    logic [XW-1:0]      w_bound;
    logic [XW-1:0]      w_idx_x;
    logic [AM_BITS-1:0] w_am_p, w_am_q, w_am_r, w_am_s;

    // handshake and pipeline advance
    assign w_s1_adv   = !r_out_valid || i_out_ready;
    assign o_in_ready = !r_s1_valid || w_s1_adv;
    assign o_cfg_ready = 1'b1;
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_emit     = w_accept && (i_command == CMD_START || i_command == CMD_ADVANCE);
    assign w_idx_x    = XW'(i_shell_index);
    assign w_load     = w_accept && i_command == CMD_LOAD && w_idx_x < XW'(MAX_SHELLS);
    assign w_bound    = (XW'(r_shell_count) < XW'(MAX_SHELLS)) ? XW'(r_shell_count)
                                                               : XW'(MAX_SHELLS);

    // counter carry chain, group size and permutation selection
    always_comb begin
        logic       twisted;
        logic       wrap;
        n_cnt_i    = r_cnt_i;
        n_cnt_j    = r_cnt_j;
        n_cnt_k    = r_cnt_k;
        n_cnt_l    = r_cnt_l;
        n_grp_pos  = r_grp_pos;
        n_grp_size = r_grp_size;
        n_done     = r_done;
        n_finished = 1'b0;
        wrap       = 1'b0;
        unique case (i_command)
            CMD_START: begin
                n_cnt_i    = '0;
                n_cnt_j    = '0;
                n_cnt_k    = '0;
                n_cnt_l    = '0;
                n_grp_pos  = 2'd0;
                n_grp_size = 2'd1;
                n_done     = 1'b0;
            end
            CMD_ADVANCE: begin
                if (r_done) begin
                    n_finished = 1'b1;
                end else begin
                    n_grp_pos = r_grp_pos + 2'd1;
                    if (n_grp_pos >= r_grp_size) begin
                        n_grp_pos = 2'd0;
                        wrap      = 1'b1;
                        n_cnt_l   = r_cnt_l + CW'(1);
                        if (n_cnt_l > r_cnt_k) begin
                            n_cnt_k = r_cnt_k + CW'(1);
                            n_cnt_l = '0;
                            if (n_cnt_k > r_cnt_j) begin
                                n_cnt_j = r_cnt_j + CW'(1);
                                n_cnt_k = '0;
                                if (n_cnt_j > r_cnt_i) begin
                                    n_cnt_i = r_cnt_i + CW'(1);
                                    n_cnt_j = '0;
                                    if (XW'(n_cnt_i) >= w_bound) begin
                                        n_done     = 1'b1;
                                        n_finished = 1'b1;
                                    end
                                end
                            end
                        end
                    end
                end
            end
            default: begin
            end
        endcase
        if (wrap) begin
            n_grp_size = grp_size_of(n_cnt_i, n_cnt_j, n_cnt_k, n_cnt_l);
        end

        // base order (i,j,k,l); alternates (i,k,j,l) or (i,l,j,k)
        n_s1_q  = n_cnt_j;
        n_s1_r  = n_cnt_k;
        n_s1_s  = n_cnt_l;
        twisted = (n_grp_size == 2'd2 && !(n_cnt_i == n_cnt_k || n_cnt_j == n_cnt_l)
                   && n_cnt_j == n_cnt_k) || n_grp_pos == 2'd2;
        if (n_grp_pos != 2'd0 && n_grp_pos < n_grp_size) begin
            n_s1_r = n_cnt_j;
            if (twisted) begin
                n_s1_q = n_cnt_l;
                n_s1_s = n_cnt_k;
            end else begin
                n_s1_q = n_cnt_k;
                n_s1_s = n_cnt_l;
            end
        end
        n_s1_flags.finished = n_finished;
        n_s1_flags.eog      = !n_finished && ({1'b0, n_grp_pos} + 3'd1 == {1'b0, n_grp_size});
    end

    // angular momentum table, two copies for four lookups a cycle
    usqg_ram #(
        .WIDTH (AM_BITS),
        .DEPTH (MAX_SHELLS)
    ) u_am_bra (
        .i_clk       (i_clk),
        .i_wr_en     (w_load),
        .i_wr_addr   (w_idx_x[AW-1:0]),
        .i_wr_data   (AM_BITS'(i_am_value)),
        .i_rd_en     (w_emit),
        .i_rd_addr_a (n_cnt_i[AW-1:0]),
        .i_rd_addr_b (n_s1_q[AW-1:0]),
        .o_rd_data_a (w_am_p),
        .o_rd_data_b (w_am_q)
    );

    usqg_ram #(
        .WIDTH (AM_BITS),
        .DEPTH (MAX_SHELLS)
    ) u_am_ket (
        .i_clk       (i_clk),
        .i_wr_en     (w_load),
        .i_wr_addr   (w_idx_x[AW-1:0]),
        .i_wr_data   (AM_BITS'(i_am_value)),
        .i_rd_en     (w_emit),
        .i_rd_addr_a (n_s1_r[AW-1:0]),
        .i_rd_addr_b (n_s1_s[AW-1:0]),
        .o_rd_data_a (w_am_r),
        .o_rd_data_b (w_am_s)
    );

    // angular momentum ordering of the quartet in stage two
    always_comb begin
        logic [CW-1:0]      p, q, r, s, t;
        logic [AM_BITS-1:0] ap, aq, ar, as, at;
        p  = r_s1_p;
        q  = r_s1_q;
        r  = r_s1_r;
        s  = r_s1_s;
        t  = '0;
        ap = w_am_p;
        aq = w_am_q;
        ar = w_am_r;
        as = w_am_s;
        at = '0;
        if (ap < aq) begin
            t = p;   p = q;   q = t;
            at = ap; ap = aq; aq = at;
        end
        if (ar < as) begin
            t = r;   r = s;   s = t;
            at = ar; ar = as; as = at;
        end
        if (SW'(ap) + SW'(aq) > SW'(ar) + SW'(as)) begin
            t = p; p = r; r = t;
            t = q; q = s; s = t;
        end
        if (r_s1_flags.finished) begin
            n_out_p = '0;
            n_out_q = '0;
            n_out_r = '0;
            n_out_s = '0;
        end else begin
            n_out_p = SHELL_W'(p);
            n_out_q = SHELL_W'(q);
            n_out_r = SHELL_W'(r);
            n_out_s = SHELL_W'(s);
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shell_count <= CNT_CFG'(1);
            r_cnt_i       <= '0;
            r_cnt_j       <= '0;
            r_cnt_k       <= '0;
            r_cnt_l       <= '0;
            r_grp_pos     <= 2'd0;
            r_grp_size    <= 2'd1;
            r_done        <= 1'b0;
            r_s1_valid    <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_shell_count <= i_cfg_data;
            end
            if (w_emit) begin
                r_cnt_i    <= n_cnt_i;
                r_cnt_j    <= n_cnt_j;
                r_cnt_k    <= n_cnt_k;
                r_cnt_l    <= n_cnt_l;
                r_grp_pos  <= n_grp_pos;
                r_grp_size <= n_grp_size;
                r_done     <= n_done;
            end
            if (o_in_ready) begin
                r_s1_valid <= w_emit;
            end
            if (w_s1_adv) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    // pipeline payload
    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_s1_flags <= n_s1_flags;
            r_s1_p     <= n_cnt_i;
            r_s1_q     <= n_s1_q;
            r_s1_r     <= n_s1_r;
            r_s1_s     <= n_s1_s;
        end
        if (w_s1_adv && r_s1_valid) begin
            r_out_p        <= n_out_p;
            r_out_q        <= n_out_q;
            r_out_r        <= n_out_r;
            r_out_s        <= n_out_s;
            r_out_eog      <= r_s1_flags.eog;
            r_out_finished <= r_s1_flags.finished;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_shell_p      = r_out_p;
    assign o_shell_q      = r_out_q;
    assign o_shell_r      = r_out_r;
    assign o_shell_s      = r_out_s;
    assign o_end_of_group = r_out_eog;
    assign o_finished     = r_out_finished;

endmodule

[rtl/core/usqg_ram.sv]
`timescale 1ns / 1ps

module usqg_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 256
) (
    input  logic                                     i_clk,
    input  logic                                     i_wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                         i_wr_data,
    input  logic                                     i_rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr_a,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr_b,
    output logic [WIDTH-1:0]                         o_rd_data_a,
    output logic [WIDTH-1:0]                         o_rd_data_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data_a;
    logic [WIDTH-1:0] r_rd_data_b;

    // one write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // two registered read ports, held while not enabled
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data_a <= r_mem[i_rd_addr_a];
            r_rd_data_b <= r_mem[i_rd_addr_b];
        end
    end

    assign o_rd_data_a = r_rd_data_a;
    assign o_rd_data_b = r_rd_data_b;

endmodule

[rtl/core/usqg_checker.sv]
`timescale 1ns / 1ps

`include "unique_shell_quartet_generator_assert.svh"

module usqg_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_in_ready,
    input logic       o_out_valid,
    input logic       i_out_ready,
    input logic [7:0] o_shell_p,
    input logic [7:0] o_shell_q,
    input logic [7:0] o_shell_r,
    input logic [7:0] o_shell_s,
    input logic       o_end_of_group,
    input logic       o_finished,
    input logic       i_cfg_valid,
    input logic       o_cfg_ready
);

    // a finished transaction carries a zero quartet and no group end
    `USQG_ASSERT_SAME(a_finished_zero, i_clk, i_rst_n, o_out_valid && o_finished,
        o_shell_p == 8'd0 && o_shell_q == 8'd0 && o_shell_r == 8'd0 &&
        o_shell_s == 8'd0 && !o_end_of_group)

    // a stalled result stays put
    `USQG_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready,
        o_out_valid && $stable(o_shell_p) && $stable(o_shell_q) &&
        $stable(o_shell_r) && $stable(o_shell_s) && $stable(o_end_of_group) &&
        $stable(o_finished))

    // the input is held off only behind a stalled result
    `USQG_ASSERT_SAME(a_in_stall, i_clk, i_rst_n, !o_in_ready, o_out_valid && !i_out_ready)

    // the shell count channel never stalls
    `USQG_ASSERT_SAME(a_cfg_ready, i_clk, i_rst_n, i_cfg_valid, o_cfg_ready)

    // reset empties the output register
    `USQG_ASSERT_NEXT_ALWAYS(a_reset_empty, i_clk, !i_rst_n, !o_out_valid)

endmodule

bind unique_shell_quartet_generator usqg_checker u_checker (.*);

[verif/quartet_order_check.sv]
`timescale 1ns / 1ps

module quartet_order_check
    import usqg_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    // command channel
    input  logic               i_in_valid,
    input  logic               i_in_ready,
    input  logic [CMD_W-1:0]   i_command,
    input  logic [IDX_W-1:0]   i_shell_index,
    input  logic [AMV_W-1:0]   i_am_value,
    // quartet channel
    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  logic [SHELL_W-1:0] i_shell_p,
    input  logic [SHELL_W-1:0] i_shell_q,
    input  logic [SHELL_W-1:0] i_shell_r,
    input  logic [SHELL_W-1:0] i_shell_s,
    input  logic               i_end_of_group,
    input  logic               i_finished,
    // shell count register
    input  logic               i_cfg_valid,
    input  logic               i_cfg_ready,
    input  logic [CNT_CFG-1:0] i_cfg_data,
    // status for the top
    output int                 o_failures,
    output int                 o_pending,
    output int                 o_quartets_seen,
    output int                 o_finished_seen
);

    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic [SHELL_W-1:0] p;
        logic [SHELL_W-1:0] q;
        logic [SHELL_W-1:0] r;
        logic [SHELL_W-1:0] s;
        logic               eog;
        logic               fin;
    } t_quartet;

    // mirrored state of the generator
    logic [AMV_W-1:0]   am_of_shell [256];
    logic [CNT_CFG-1:0] shell_count;
    logic [8:0]         ctr_i;
    logic [7:0]         ctr_j;
    logic [7:0]         ctr_k;
    logic [7:0]         ctr_l;
    logic [1:0]         perm_pos;
    logic [1:0]         perm_count;
    logic               enum_done;

    t_quartet           expected_quartets [$];
    t_quartet           got;
    t_quartet           want;

    // number of distinct permutations at the current counter position
    function automatic logic [1:0] perms_at_position();
        if ((ctr_i == ctr_j && ctr_i == ctr_k) || (ctr_j == ctr_k && ctr_j == ctr_l))
            return 2'd1;
        if (ctr_i == ctr_k || ctr_j == ctr_l || ctr_j == ctr_k || ctr_i == ctr_j ||
            ctr_k == ctr_l)
            return 2'd2;
        return 2'd3;
    endfunction

    // permutation at the current position, then ordered by angular momentum
    function automatic t_quartet ordered_quartet();
        logic [7:0] p, q, r, s, t;
        logic       twisted;
        logic [4:0] bra_sum, ket_sum;
        t_quartet   res;
        p = ctr_i[7:0];
        q = ctr_j;
        r = ctr_k;
        s = ctr_l;
        if (perm_pos != 2'd0 && perm_pos < perm_count) begin
            twisted = (perm_count == 2'd2 && !(ctr_i == ctr_k || ctr_j == ctr_l) &&
                       ctr_j == ctr_k) || perm_pos == 2'd2;
            if (twisted) begin
                q = ctr_l;
                r = ctr_j;
                s = ctr_k;
            end else begin
                q = ctr_k;
                r = ctr_j;
                s = ctr_l;
            end
        end
        if (am_of_shell[p] < am_of_shell[q]) begin
            t = p;
            p = q;
            q = t;
        end
        if (am_of_shell[r] < am_of_shell[s]) begin
            t = r;
            r = s;
            s = t;
        end
        bra_sum = am_of_shell[p] + am_of_shell[q];
        ket_sum = am_of_shell[r] + am_of_shell[s];
        if (bra_sum > ket_sum) begin
            t = p;
            p = r;
            r = t;
            t = q;
            q = s;
            s = t;
        end
        res.p   = p;
        res.q   = q;
        res.r   = r;
        res.s   = s;
        res.eog = (perm_pos + 2'd1 == perm_count);
        res.fin = 1'b0;
        return res;
    endfunction

    function automatic t_quartet finished_quartet();
        t_quartet res;
        res     = '0;
        res.fin = 1'b1;
        return res;
    endfunction

    // step to the next permutation, carrying through l, k, j, i
    function automatic void advance_enumeration();
        logic [8:0] limit;
        limit = (shell_count > 9'd256) ? 9'd256 : shell_count;
        if (enum_done) begin
            expected_quartets.push_back(finished_quartet());
            return;
        end
        perm_pos = perm_pos + 2'd1;
        if (perm_pos >= perm_count) begin
            perm_pos = 2'd0;
            if (ctr_l != ctr_k) begin
                ctr_l = ctr_l + 8'd1;
            end else begin
                ctr_l = 8'd0;
                if (ctr_k != ctr_j) begin
                    ctr_k = ctr_k + 8'd1;
                end else begin
                    ctr_k = 8'd0;
                    if ({1'b0, ctr_j} != ctr_i) begin
                        ctr_j = ctr_j + 8'd1;
                    end else begin
                        ctr_j = 8'd0;
                        ctr_i = ctr_i + 9'd1;
                        if (ctr_i >= limit) begin
                            enum_done = 1'b1;
                            expected_quartets.push_back(finished_quartet());
                            return;
                        end
                    end
                end
            end
            perm_count = perms_at_position();
        end
        expected_quartets.push_back(ordered_quartet());
    endfunction

    function automatic void clear_counters();
        ctr_i      = '0;
        ctr_j      = '0;
        ctr_k      = '0;
        ctr_l      = '0;
        perm_pos   = 2'd0;
        perm_count = 2'd1;
        enum_done  = 1'b0;
    endfunction

    function automatic void note_failure();
        if (o_failures < REPORT_LIMIT) begin
            if (expected_quartets.size() == 0 && want.fin === 1'bx)
                $display("unexpected quartet p=%0d q=%0d r=%0d s=%0d eog=%0b fin=%0b",
                         got.p, got.q, got.r, got.s, got.eog, got.fin);
            else
                $display({"quartet mismatch: expected p=%0d q=%0d r=%0d s=%0d eog=%0b ",
                          "fin=%0b, got p=%0d q=%0d r=%0d s=%0d eog=%0b fin=%0b"},
                         want.p, want.q, want.r, want.s, want.eog, want.fin,
                         got.p, got.q, got.r, got.s, got.eog, got.fin);
        end
        o_failures++;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int n = 0; n < 256; n++)
                am_of_shell[n] = '0;
            shell_count = 9'd1;
            clear_counters();
            expected_quartets.delete();
            o_failures      = 0;
            o_quartets_seen = 0;
            o_finished_seen = 0;
        end else begin
            // register write
            if (i_cfg_valid && i_cfg_ready)
                shell_count = i_cfg_data;

            // quartet transaction against the oldest prediction
            if (i_out_valid && i_out_ready) begin
                got.p   = i_shell_p;
                got.q   = i_shell_q;
                got.r   = i_shell_r;
                got.s   = i_shell_s;
                got.eog = i_end_of_group;
                got.fin = i_finished;
                o_quartets_seen++;
                if (i_finished)
                    o_finished_seen++;
                if (expected_quartets.size() == 0) begin
                    want = 'x;
                    note_failure();
                end else begin
                    want = expected_quartets.pop_front();
                    if (got.p !== want.p || got.q !== want.q || got.r !== want.r ||
                        got.s !== want.s || got.eog !== want.eog || got.fin !== want.fin)
                        note_failure();
                end
            end

            // command transaction
            if (i_in_valid && i_in_ready) begin
                case (i_command)
                    CMD_LOAD: begin
                        am_of_shell[i_shell_index] = i_am_value;
                    end
                    CMD_START: begin
                        clear_counters();
                        expected_quartets.push_back(ordered_quartet());
                    end
                    CMD_ADVANCE: begin
                        advance_enumeration();
                    end
                    default: ;
                endcase
            end
        end
        o_pending = expected_quartets.size();
    end

endmodule

[verif/testbench.sv]
`timescale 1ns / 1ps

module testbench;
    import usqg_pkg::*;

    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    localparam int RANDOM_ITEMS   = 950;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_CYCLES    = 80;
    localparam int SETTLE_CYCLES  = 4;
    localparam int DRAIN_CYCLES   = 10;
    localparam int IDLE_PERCENT   = 28;
    localparam int CALM_FROM      = 450;
    localparam int CALM_SPAN      = 150;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic [CMD_W-1:0]   command;
    logic [IDX_W-1:0]   shell_index;
    logic [AMV_W-1:0]   am_value;
    logic               out_valid;
    logic               out_ready;
    logic [SHELL_W-1:0] shell_p;
    logic [SHELL_W-1:0] shell_q;
    logic [SHELL_W-1:0] shell_r;
    logic [SHELL_W-1:0] shell_s;
    logic               end_of_group;
    logic               finished;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [CNT_CFG-1:0] cfg_data;

    int failures;
    int pending;
    int quartets_seen;
    int finished_seen;
    int sent_items;
    int count_writes;
    int stall_cycles;
    bit calm;
    bit hold_request;
    bit am_loaded [256];

    unique_shell_quartet_generator dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .o_in_ready     (in_ready),
        .i_command      (command),
        .i_shell_index  (shell_index),
        .i_am_value     (am_value),
        .o_out_valid    (out_valid),
        .i_out_ready    (out_ready),
        .o_shell_p      (shell_p),
        .o_shell_q      (shell_q),
        .o_shell_r      (shell_r),
        .o_shell_s      (shell_s),
        .o_end_of_group (end_of_group),
        .o_finished     (finished),
        .i_cfg_valid    (cfg_valid),
        .o_cfg_ready    (cfg_ready),
        .i_cfg_data     (cfg_data)
    );

    quartet_order_check order_check (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (in_valid),
        .i_in_ready      (in_ready),
        .i_command       (command),
        .i_shell_index   (shell_index),
        .i_am_value      (am_value),
        .i_out_valid     (out_valid),
        .i_out_ready     (out_ready),
        .i_shell_p       (shell_p),
        .i_shell_q       (shell_q),
        .i_shell_r       (shell_r),
        .i_shell_s       (shell_s),
        .i_end_of_group  (end_of_group),
        .i_finished      (finished),
        .i_cfg_valid     (cfg_valid),
        .i_cfg_ready     (cfg_ready),
        .i_cfg_data      (cfg_data),
        .o_failures      (failures),
        .o_pending       (pending),
        .o_quartets_seen (quartets_seen),
        .o_finished_seen (finished_seen)
    );

    // clock
    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // watchdog on cycles with no transaction on any channel
    always @(posedge clk) begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
            (cfg_valid && cfg_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("no transaction for %0d cycles", WATCHDOG_LIMIT);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // quartet receiver: random stalls, one long hold-off on request
    initial begin
        out_ready <= 1'b0;
        wait (rst_n);
        forever begin
            @(posedge clk);
            if (hold_request) begin
                hold_request = 1'b0;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            out_ready <= calm || ($urandom_range(99) >= IDLE_PERCENT);
        end
    end

    // one command transaction, with random idle cycles ahead of it
    task automatic put_command(input logic [CMD_W-1:0] cmd, input logic [IDX_W-1:0] idx,
                               input logic [AMV_W-1:0] am);
        while (!calm && $urandom_range(99) < IDLE_PERCENT) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        command     <= cmd;
        shell_index <= idx;
        am_value    <= am;
        do @(posedge clk); while (!in_ready);
        if (cmd == CMD_LOAD)
            am_loaded[idx] = 1'b1;
        if (cmd != CMD_UNUSED)
            sent_items++;
    endtask

    task automatic advance();
        put_command(CMD_ADVANCE, IDX_W'($urandom_range(255)), AMV_W'($urandom_range(15)));
    endtask

    task automatic start_run();
        put_command(CMD_START, IDX_W'($urandom_range(255)), AMV_W'($urandom_range(15)));
    endtask

    // make sure every shell below the count has an angular momentum
    task automatic fill_table(input int shells);
        for (int n = 0; n < shells; n++)
            if (!am_loaded[n])
                put_command(CMD_LOAD, n[7:0], AMV_W'($urandom_range(15)));
    endtask

    // drain the generator, then write the shell count
    task automatic write_shell_count(input logic [CNT_CFG-1:0] value);
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        count_writes++;
    endtask

    // counter positions i >= j >= k >= l for a basis of n shells
    function automatic int positions(input int n);
        return n * (n + 1) * (n + 2) * (n + 3) / 24;
    endfunction

    initial begin
        int  r;
        int  shells;
        int  run_len;
        int  stop_at;
        int  phase;
        bit  keep_counters;
        bit  held;

        rst_n       <= 1'b0;
        in_valid    <= 1'b0;
        command     <= CMD_LOAD;
        shell_index <= '0;
        am_value    <= '0;
        cfg_valid   <= 1'b0;
        cfg_data    <= '0;
        calm         = 1'b0;
        hold_request = 1'b0;
        held         = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // directed: field extremes, advance straight out of reset, unused command
        put_command(CMD_LOAD, 8'd0, 4'd15);
        put_command(CMD_LOAD, 8'd255, 4'd0);
        put_command(CMD_LOAD, 8'hAA, 4'd5);
        put_command(CMD_LOAD, 8'h55, 4'd10);
        advance();
        advance();
        put_command(CMD_UNUSED, 8'hFF, 4'hF);
        start_run();

        // empty basis: start still gives the zero quartet, advance finishes
        write_shell_count(9'd0);
        start_run();
        advance();

        // two shells walked to the end and past it
        write_shell_count(9'd2);
        put_command(CMD_LOAD, 8'd1, 4'd3);
        start_run();
        repeat (7) advance();

        // random phases: mostly small bases walked deep, some large ones
        stop_at = sent_items + RANDOM_ITEMS;
        phase   = 0;
        while (sent_items < stop_at) begin
            r = $urandom_range(99);
            if (phase == 0)
                shells = 511;
            else if (phase == 1)
                shells = 256;
            else if (r < 68)
                shells = $urandom_range(1, 5);
            else if (r < 76)
                shells = 0;
            else if (r < 86)
                shells = $urandom_range(6, 40);
            else if (r < 92)
                shells = 256;
            else if (r < 96)
                shells = 511;
            else
                shells = $urandom_range(257, 510);
            // sometimes change the count without restarting
            keep_counters = (phase > 1) && ($urandom_range(4) == 0);
            phase++;

            write_shell_count(shells[CNT_CFG-1:0]);
            fill_table(shells > 256 ? 256 : shells);
            if (!keep_counters)
                start_run();

            if (shells >= 1 && shells <= 5)
                run_len = $urandom_range(1, 3 * positions(shells) + 4);
            else
                run_len = $urandom_range(1, 80);

            for (int n = 0; n < run_len && sent_items < stop_at; n++) begin
                calm = (sent_items >= CALM_FROM && sent_items < CALM_FROM + CALM_SPAN);
                if (!held && sent_items > 300) begin
                    hold_request = 1'b1;
                    held         = 1'b1;
                end
                r = $urandom_range(99);
                if (r < 8)
                    put_command(CMD_LOAD, IDX_W'($urandom_range(255)),
                                AMV_W'($urandom_range(15)));
                else if (r < 11)
                    put_command(CMD_UNUSED, IDX_W'($urandom_range(255)),
                                AMV_W'($urandom_range(15)));
                else if (r < 14)
                    start_run();
                else
                    advance();
            end
        end
        calm = 1'b0;

        // drain and report
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("%0d command transactions over %0d shell count settings",
                 sent_items, count_writes);
        $display("%0d quartets checked, %0d of them past the end of the enumeration",
                 quartets_seen, finished_seen);
        if (failures == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
